@@ hdl/fps_pkg.sv @@
// Shared types and character constants for the format string printer.
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharD       = 8'h64;
  localparam logic [7:0] CharX       = 8'h78;
  localparam logic [7:0] CharMinus   = 8'h2d;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharA       = 8'h61;

  localparam int unsigned NumDigits = 10;
  localparam int unsigned ArgWidth  = 32;

  localparam logic [3:0] DigCount = 4'd10;
  localparam logic [3:0] DecBase  = 4'd10;
  localparam logic [4:0] BitLast  = 5'd31;
  localparam int unsigned SignBit = 31;

  typedef struct packed {
    logic [7:0]  format_char;
    logic [31:0] argument;
  } fps_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } fps_out_t;

  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic load_chr;
    logic dabble;
    logic shift;
    logic emit_sign;
    logic emit_dig;
    logic emit_chr;
  } fps_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic cnt_one;
    logic neg;
    logic bits_done;
    logic out_free;
  } fps_sts_t;

endpackage

`default_nettype wire

@@ hdl/format_string_printer.sv @@
// Top level of the format string printer: controller plus datapath.
//
// Input channel (in_valid_i/in_ready_o/in_i) carries one format byte and
// a 32-bit argument per transfer. Output channel (out_valid_o/out_ready_i/
// out_o) carries one character per transfer; last_of_run marks the final
// character caused by an input byte. A '%' or an unknown directive byte
// produces no output transfer.
// With an idle receiver: a plain byte or the terminator passes through a
// character register into the output register. A %x directive skips
// leading zero nibbles one at a time (at most 9), makes a decision step,
// then emits one character per cycle. A %d directive first shifts all 32
// argument bits through the shift-and-add-3 BCD converter, then skips
// leading zeros and emits the sign and digits one per cycle.
// One input byte is worked on at a time; the next is taken once the last
// character of the run sits in the output register.
// Reset clears the pending-directive flag and the output valid.
// When the receiver stalls, the output register holds its character and
// the sequence waits.
`timescale 1ns / 1ps
`default_nettype none

module format_string_printer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fps_pkg::fps_in_t  in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fps_pkg::fps_out_t      out_o
);
  import fps_pkg::*;

  fps_cmd_t cmd;
  fps_sts_t sts;

  fps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .format_char_i (in_i.format_char),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  fps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

`default_nettype wire

@@ hdl/fps_dp.sv @@
// Datapath: binary to BCD converter, digit shifter and output register.
`timescale 1ns / 1ps
`default_nettype none

module fps_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fps_pkg::fps_in_t in_i,
  input  wire fps_pkg::fps_cmd_t cmd_i,
  output fps_pkg::fps_sts_t     sts_o,
  output fps_pkg::fps_out_t     out_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i
);
  import fps_pkg::*;

  logic [4*NumDigits-1:0] bcd_q, bcd_d, bcd_adj;
  logic [ArgWidth-1:0]    bin_q, bin_d, mag;
  logic [7:0]             chr_q, chr_d;
  logic                   neg_q, neg_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [4:0]             bit_cnt_q, bit_cnt_d;
  fps_out_t               out_q, out_d;
  logic                   out_valid_q, out_valid_d;
  logic [3:0]             top_dig;
  logic [7:0]             dig_chr;
  logic                   out_free;

  assign mag = in_i.argument[SignBit] ? (~in_i.argument + 32'd1) : in_i.argument;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign top_dig = bcd_q[4*NumDigits-1 -: 4];
  assign dig_chr = (top_dig < DecBase) ? (CharZero + {4'b0, top_dig})
                                       : (CharA + {4'b0, top_dig} - {4'b0, DecBase});
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    bcd_d       = bcd_q;
    bin_d       = bin_q;
    chr_d       = chr_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    bit_cnt_d   = bit_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load_dec) begin
      bcd_d     = '0;
      bin_d     = mag;
      neg_d     = in_i.argument[SignBit];
      cnt_d     = DigCount;
      bit_cnt_d = '0;
    end
    if (cmd_i.load_hex) begin
      bcd_d = {{(4*NumDigits-ArgWidth){1'b0}}, in_i.argument};
      neg_d = 1'b0;
      cnt_d = DigCount;
    end
    if (cmd_i.load_chr) begin
      chr_d = in_i.format_char;
    end
    if (cmd_i.dabble) begin
      bcd_d     = {bcd_adj[4*NumDigits-2:0], bin_q[ArgWidth-1]};
      bin_d     = {bin_q[ArgWidth-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q + 5'd1;
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_q[4*NumDigits-5:0], 4'h0};
      cnt_d = cnt_q - 4'd1;
    end
    if (cmd_i.emit_sign) begin
      out_d       = '{out_char: CharMinus, last_of_run: 1'b0};
      out_valid_d = 1'b1;
    end
    if (cmd_i.emit_dig) begin
      out_d       = '{out_char: dig_chr, last_of_run: (cnt_q == 4'd1)};
      out_valid_d = 1'b1;
    end
    if (cmd_i.emit_chr) begin
      out_d       = '{out_char: chr_q, last_of_run: 1'b1};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      bit_cnt_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      bit_cnt_q   <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
    chr_q <= chr_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  assign sts_o.top_zero  = (top_dig == 4'h0);
  assign sts_o.cnt_one   = (cnt_q == 4'd1);
  assign sts_o.neg       = neg_q;
  assign sts_o.bits_done = (bit_cnt_q == BitLast);
  assign sts_o.out_free  = out_free;
  assign out_o           = out_q;
  assign out_valid_o     = out_valid_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DigCount) else $error("digit count out of range");

endmodule

`default_nettype wire

@@ hdl/fps_ctrl.sv @@
// Controller: decodes format bytes and sequences conversion and emission.
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        format_char_i,
  input  wire fps_pkg::fps_sts_t sts_i,
  output fps_pkg::fps_cmd_t      cmd_o
);
  import fps_pkg::*;

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StDabble  = 6'b000010,
    StSkip    = 6'b000100,
    StSign    = 6'b001000,
    StDigit   = 6'b010000,
    StChar    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pending_q, pending_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    cmd_o     = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (format_char_i == CharNul) begin
            pending_d      = 1'b0;
            cmd_o.load_chr = 1'b1;
            state_d        = StChar;
          end else if (pending_q) begin
            pending_d = 1'b0;
            if (format_char_i == CharD) begin
              cmd_o.load_dec = 1'b1;
              state_d        = StDabble;
            end else if (format_char_i == CharX) begin
              cmd_o.load_hex = 1'b1;
              state_d        = StSkip;
            end
          end else if (format_char_i == CharPercent) begin
            pending_d = 1'b1;
          end else begin
            cmd_o.load_chr = 1'b1;
            state_d        = StChar;
          end
        end
      end
      StDabble: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.bits_done) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (sts_i.top_zero && !sts_i.cnt_one) begin
          cmd_o.shift = 1'b1;
        end else if (sts_i.neg) begin
          state_d = StSign;
        end else begin
          state_d = StDigit;
        end
      end
      StSign: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StDigit;
        end
      end
      StDigit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_dig = 1'b1;
          cmd_o.shift    = 1'b1;
          if (sts_i.cnt_one) begin
            state_d = StIdle;
          end
        end
      end
      StChar: begin
        if (sts_i.out_free) begin
          cmd_o.emit_chr = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

  a_last_digit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigit && sts_i.out_free && sts_i.cnt_one) |=> state_q == StIdle)
    else $error("run did not end after its last digit");

  a_dabble_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDabble && !sts_i.bits_done) |=> state_q == StDabble)
    else $error("conversion left early");

  a_pending_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> $past(accept && format_char_i == CharPercent))
    else $error("directive flag set without a percent byte");

  a_no_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_sign || cmd_o.emit_dig || cmd_o.emit_chr) |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire
